// ----- design/chl_pkg.sv -----
// ----------------------------------------------------------------------------
// chl_pkg: shared types and constants for the chained hash table lookup
// Command codes, the queued operation record and the back-end state type.
// ----------------------------------------------------------------------------
package chl_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_INSERT    = 3'd1,
        CMD_FIND      = 3'd2,
        CMD_NAME_BYTE = 3'd3,
        CMD_INS_NAME  = 3'd4,
        CMD_FIND_NAME = 3'd5,
        CMD_RSVD6     = 3'd6,
        CMD_RSVD7     = 3'd7
    } cmd_t;

    // Shift amounts of the sdbm name hash.
    localparam int SDBM_SHIFT_A = 6;
    localparam int SDBM_SHIFT_B = 16;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] hash;
        logic [7:0]  slot;
    } op_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_INS_WR,
        ST_FIND_CACHE,
        ST_WALK,
        ST_WALK_CMP,
        ST_DONE
    } state_t;

endpackage

// ----- design/chl_ram.sv -----
// ----------------------------------------------------------------------------
// chl_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/chl_front.sv -----
// ----------------------------------------------------------------------------
// chl_front: command front end
// Accepts beats, keeps the running name hash and forms queued operations.
// ----------------------------------------------------------------------------
module chl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    command,
    input  logic [63:0]   key_hash,
    input  logic [7:0]    entry_index,
    input  logic [7:0]    name_char,
    output logic          op_valid,
    input  logic          op_ready,
    output chl_pkg::op_t  op
);
    import chl_pkg::*;

    logic [63:0] acc_reg, acc_next, acc_upd;
    cmd_t        cmd;

    assign cmd      = cmd_t'(command);
    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign acc_upd  = 64'(name_char) + (acc_reg << SDBM_SHIFT_A)
                    + (acc_reg << SDBM_SHIFT_B) - acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        op.cmd   = cmd;
        op.slot  = entry_index;
        op.hash  = 64'd0;
        unique case (cmd)
            CMD_INSERT, CMD_FIND: op.hash = key_hash;
            CMD_NAME_BYTE:
            begin
                if (name_char != 8'd0)
                begin
                    acc_next = acc_upd;
                end
                op.hash = acc_next;
            end
            CMD_INS_NAME, CMD_FIND_NAME:
            begin
                op.hash  = acc_reg;
                acc_next = 64'd0;
            end
            default: op.hash = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 64'd0;
        end
        else if (in_valid && op_ready)
        begin
            acc_reg <= acc_next;
        end
    end
endmodule

// ----- design/chl_queue.sv -----
// ----------------------------------------------------------------------------
// chl_queue: two-entry operation queue
// Decouples the front end from the table sequencer.
// ----------------------------------------------------------------------------
module chl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  chl_pkg::op_t  wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output chl_pkg::op_t  rd_op
);
    import chl_pkg::*;

    op_t        slots_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = slots_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- design/chl_back.sv -----
// ----------------------------------------------------------------------------
// chl_back: table sequencer
// Runs insert, find and clear against the bucket and entry memories.
// ----------------------------------------------------------------------------
module chl_back #(
    parameter int BUCKETS = 256,
    parameter int ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  chl_pkg::op_t  op,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          found,
    output logic [7:0]    found_entry,
    output logic [63:0]   used_hash
);
    import chl_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);
    localparam logic [PW-1:0] EMPTY = PW'(ENTRIES);

    state_t        state_reg, state_next;
    op_t           op_reg;
    logic [PW-1:0] last_hit_reg, e_reg, steps_reg;
    logic [BW-1:0] sweep_reg;
    logic          clr_pending_reg;
    logic          res_found_reg;
    logic [7:0]    res_entry_reg;
    logic          out_valid_reg, out_found_reg;
    logic [7:0]    out_entry_reg;
    logic [63:0]   out_hash_reg;

    logic          head_we, ent_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [PW-1:0] head_wdata, head_rdata, next_rdata;
    logic [EW-1:0] ent_waddr, ent_raddr;
    logic [63:0]   hash_rdata;
    logic          slot_ok, cache_hit, walk_end;

    assign slot_ok   = (32'(op.slot) < ENTRIES);
    assign cache_hit = (last_hit_reg < EMPTY) && (hash_rdata == op_reg.hash);
    assign walk_end  = (e_reg >= EMPTY) || (steps_reg >= EMPTY);

    chl_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    chl_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_next (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(head_rdata),
        .raddr(ent_raddr), .rdata(next_rdata)
    );
    chl_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_hashes (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(op_reg.hash),
        .raddr(ent_raddr), .rdata(hash_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_reg == BW'(BUCKETS - 1))
                begin
                    state_next = clr_pending_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    unique case (op.cmd)
                        CMD_CLEAR:                 state_next = ST_SWEEP;
                        CMD_INSERT, CMD_INS_NAME:  state_next = slot_ok ? ST_INS_WR : ST_DONE;
                        CMD_FIND, CMD_FIND_NAME:   state_next = ST_FIND_CACHE;
                        default:                   state_next = ST_DONE;
                    endcase
                end
            end
            ST_INS_WR:     state_next = ST_DONE;
            ST_FIND_CACHE: state_next = cache_hit ? ST_DONE : ST_WALK;
            ST_WALK:       state_next = walk_end ? ST_DONE : ST_WALK_CMP;
            ST_WALK_CMP:   state_next = (hash_rdata == op_reg.hash) ? ST_DONE : ST_WALK;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Memory control.
    always_comb
    begin
        op_ready   = (state_reg == ST_IDLE);
        head_we    = 1'b0;
        head_waddr = sweep_reg;
        head_wdata = EMPTY;
        head_raddr = BW'(op.hash) & BW'(BUCKETS - 1);
        ent_we     = 1'b0;
        ent_waddr  = EW'(op_reg.slot);
        ent_raddr  = EW'(last_hit_reg);
        unique case (state_reg)
            ST_SWEEP:  head_we = 1'b1;
            ST_INS_WR:
            begin
                head_we    = 1'b1;
                head_waddr = BW'(op_reg.hash) & BW'(BUCKETS - 1);
                head_wdata = PW'(op_reg.slot);
                ent_we     = 1'b1;
            end
            ST_WALK:   ent_raddr = EW'(e_reg);
            default:   ent_raddr = EW'(last_hit_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && op_valid)
        begin
            op_reg        <= op;
            res_found_reg <= 1'b0;
            res_entry_reg <= 8'd0;
        end
        if (state_reg == ST_FIND_CACHE)
        begin
            e_reg     <= head_rdata;
            steps_reg <= '0;
            if (cache_hit)
            begin
                res_found_reg <= 1'b1;
                res_entry_reg <= 8'(last_hit_reg);
            end
        end
        if (state_reg == ST_WALK_CMP)
        begin
            if (hash_rdata == op_reg.hash)
            begin
                res_found_reg <= 1'b1;
                res_entry_reg <= 8'(e_reg);
            end
            else
            begin
                e_reg     <= next_rdata;
                steps_reg <= steps_reg + PW'(1);
            end
        end
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_found_reg <= res_found_reg;
            out_entry_reg <= res_entry_reg;
            out_hash_reg  <= op_reg.hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_reg       <= '0;
            clr_pending_reg <= 1'b0;
            last_hit_reg    <= EMPTY;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
            begin
                if (sweep_reg == BW'(BUCKETS - 1))
                begin
                    sweep_reg       <= '0;
                    clr_pending_reg <= 1'b0;
                end
                else
                begin
                    sweep_reg <= sweep_reg + BW'(1);
                end
            end
            if (state_reg == ST_IDLE && op_valid && op.cmd == CMD_CLEAR)
            begin
                clr_pending_reg <= 1'b1;
                last_hit_reg    <= EMPTY;
            end
            if (state_reg == ST_WALK && walk_end)
            begin
                last_hit_reg <= EMPTY;
            end
            if (state_reg == ST_WALK_CMP && hash_rdata == op_reg.hash)
            begin
                last_hit_reg <= e_reg;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign found_entry = out_entry_reg;
    assign used_hash   = out_hash_reg;
endmodule

// ----- design/chained_hash_table_lookup.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_lookup: chained hash table with a last-hit cache
// Front end, operation queue and table sequencer with bucket/entry RAMs.
// ----------------------------------------------------------------------------
// One result beat comes out for every command beat, in order. Name bytes and
// unused commands go straight to the result, an insert with a valid slot writes
// the head and entry RAMs together, and a find checks the last-hit cache and
// otherwise walks the chain, reading an entry from the entry RAMs and then
// comparing it. Clear, and the pass that follows reset, write the bucket head
// RAM one bucket per cycle; meanwhile commands are queued (up to two) but
// not executed.
module chained_hash_table_lookup #(
    parameter int BUCKETS = 256,
    parameter int ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [63:0] key_hash,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  name_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [7:0]  found_entry,
    output logic [63:0] used_hash
);
    import chl_pkg::*;

    op_t  f_op, q_op;
    logic f_valid, f_ready, q_valid, q_ready;

    chl_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key_hash(key_hash), .entry_index(entry_index),
        .name_char(name_char), .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
    );

    chl_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_op(f_op), .rd_valid(q_valid), .rd_ready(q_ready), .rd_op(q_op)
    );

    chl_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .op_valid(q_valid), .op_ready(q_ready),
        .op(q_op), .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .found_entry(found_entry), .used_hash(used_hash)
    );

    // A miss always reports slot zero.
    a_miss_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (found_entry == 8'd0))
        else $error("miss reported a nonzero slot");

    // A result that is not taken stays on the output.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(used_hash)))
        else $error("pending result changed");
endmodule

// ----- test/tb_chained_hash_table_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_table_lookup: self-checking bench for the chained hash table
// Drives clear, insert, find, name-hash and reserved commands with random handshake
// pacing. A scoreboard keeps its own copy of the table and the cache and
// checks every result beat against it, in order.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_lookup;
    import chl_pkg::*;

    localparam int NBKT = 256;
    localparam int NENT = 256;

    typedef struct {
        logic        hit;
        logic [7:0]  slot;
        logic [63:0] hash;
    } lookup_result_t;

    class hash_table_scoreboard;
        logic [8:0]     heads [NBKT];
        logic [8:0]     links [NENT];
        logic [63:0]    hashes [NENT];
        logic [8:0]     cached;
        logic [63:0]    name_acc;
        lookup_result_t awaited [$];
        int             errors;
        int             checked;
        int             hits;

        function new();
            foreach (heads[i]) heads[i] = 9'(NENT);
            foreach (links[i]) links[i] = 9'(NENT);
            foreach (hashes[i]) hashes[i] = '0;
            cached   = 9'(NENT);
            name_acc = '0;
            errors   = 0;
            checked  = 0;
            hits     = 0;
        endfunction

        function void link_slot(logic [63:0] h, logic [7:0] s);
            links[s]       = heads[h[7:0]];
            hashes[s]      = h;
            heads[h[7:0]]  = {1'b0, s};
        endfunction

        function logic lookup(logic [63:0] h, output logic [7:0] s);
            logic [8:0] e;
            int         steps;
            s = '0;
            if (cached < NENT && hashes[cached[7:0]] == h)
            begin
                s = cached[7:0];
                return 1'b1;
            end
            e     = heads[h[7:0]];
            steps = 0;
            while (e < NENT && steps < NENT)
            begin
                if (hashes[e[7:0]] == h)
                begin
                    cached = e;
                    s      = e[7:0];
                    return 1'b1;
                end
                e = links[e[7:0]];
                steps++;
            end
            cached = 9'(NENT);
            return 1'b0;
        endfunction

        function void note_input(cmd_t cmd, logic [63:0] key, logic [7:0] idx,
                                 logic [7:0] ch);
            lookup_result_t r;
            r.hit  = 1'b0;
            r.slot = '0;
            r.hash = '0;
            case (cmd)
                CMD_CLEAR:
                begin
                    foreach (heads[i]) heads[i] = 9'(NENT);
                    cached = 9'(NENT);
                end
                CMD_INSERT:
                begin
                    link_slot(key, idx);
                    r.hash = key;
                end
                CMD_FIND:
                begin
                    r.hit  = lookup(key, r.slot);
                    r.hash = key;
                end
                CMD_NAME_BYTE:
                begin
                    if (ch != 0)
                        name_acc = {56'b0, ch} + (name_acc << SDBM_SHIFT_A)
                                   + (name_acc << SDBM_SHIFT_B) - name_acc;
                    r.hash = name_acc;
                end
                CMD_INS_NAME:
                begin
                    r.hash = name_acc;
                    link_slot(name_acc, idx);
                    name_acc = '0;
                end
                CMD_FIND_NAME:
                begin
                    r.hash   = name_acc;
                    r.hit    = lookup(name_acc, r.slot);
                    name_acc = '0;
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic f, logic [7:0] s, logic [63:0] h);
            lookup_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result beat found=%0b entry=%0d hash=%h",
                         $time, f, s, h);
                errors++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (e.hit) hits++;
            if (f !== e.hit)
            begin
                $display("%0t: found expected %0b actual %0b", $time, e.hit, f);
                errors++;
            end
            if (s !== e.slot)
            begin
                $display("%0t: found_entry expected %0d actual %0d", $time, e.slot, s);
                errors++;
            end
            if (h !== e.hash)
            begin
                $display("%0t: used_hash expected %h actual %h", $time, e.hash, h);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [63:0] key_hash;
    logic [7:0]  entry_index;
    logic [7:0]  name_char;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [7:0]  found_entry;
    logic [63:0] used_hash;

    hash_table_scoreboard sb;
    int          send_gap_pct;
    int          recv_stall_pct;
    int          beats_sent;
    logic        linked [NENT];
    logic [63:0] key_pool [$];
    logic [7:0]  names [16][6];
    int          name_len [16];
    logic        name_stored [16];

    chained_hash_table_lookup u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .key_hash    (key_hash),
        .entry_index (entry_index),
        .name_char   (name_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .found_entry (found_entry),
        .used_hash   (used_hash)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(cmd_t'(command), key_hash, entry_index, name_char);
        if (rst_n && out_valid && out_ready)
            sb.check_result(found, found_entry, used_hash);
    end

    // Receiver pacing; in the last phase the stall rate is zero.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send(cmd_t cmd, logic [63:0] key, logic [7:0] idx, logic [7:0] ch);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        key_hash    <= key;
        entry_index <= idx;
        name_char   <= ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        if (cmd == CMD_CLEAR)
            foreach (linked[i]) linked[i] = 1'b0;
        if (cmd == CMD_INSERT || cmd == CMD_INS_NAME)
            linked[idx] = 1'b1;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] free_slot();
        int s;
        s = $urandom_range(NENT - 1);
        for (int i = 0; i < NENT && linked[s]; i++)
            s = (s + 1) % NENT;
        return s[7:0];
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int          pick;
        int          n;
        logic [63:0] k;
        logic [7:0]  s;
        pick = $urandom_range(99);
        if (pick < 1)
        begin
            send(CMD_CLEAR, rand_key(), 8'($urandom), 8'($urandom));
            foreach (name_stored[i]) name_stored[i] = 1'b0;
            key_pool.delete();
        end
        else if (pick < 30)
        begin
            s = free_slot();
            // Mostly fresh slots; a few are relinked on purpose.
            if (linked[s] || $urandom_range(49) == 0)
                s = 8'($urandom);
            if (linked[s] == 1'b0 || $urandom_range(3) == 0)
            begin
                k = rand_key();
                // Bias some keys into a few buckets to build long chains.
                if ($urandom_range(1)) k[7:0] = 8'($urandom_range(3));
                send(CMD_INSERT, k, s, 8'($urandom));
                key_pool.push_back(k);
            end
            else
            begin
                send(CMD_CLEAR, '0, '0, '0);
                foreach (name_stored[i]) name_stored[i] = 1'b0;
                key_pool.delete();
            end
        end
        else if (pick < 60)
        begin
            if (key_pool.size() != 0 && $urandom_range(3) != 0)
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                k = rand_key();
            send(CMD_FIND, k, 8'($urandom), 8'($urandom));
        end
        else if (pick < 96)
        begin
            n = $urandom_range(15);
            for (int i = 0; i < name_len[n]; i++)
                send(CMD_NAME_BYTE, rand_key(), 8'($urandom),
                     ($urandom_range(19) == 0) ? 8'd0 : names[n][i]);
            s = free_slot();
            if (!name_stored[n] && !linked[s] && $urandom_range(1))
            begin
                send(CMD_INS_NAME, rand_key(), s, 8'($urandom));
                name_stored[n] = 1'b1;
            end
            else
                send(CMD_FIND_NAME, rand_key(), 8'($urandom), 8'($urandom));
        end
        else
            send(($urandom_range(1)) ? CMD_RSVD6 : CMD_RSVD7, rand_key(),
                 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_CLEAR;
        key_hash       = '0;
        entry_index    = '0;
        name_char      = '0;
        out_ready      = 1'b0;
        send_gap_pct   = 19;
        recv_stall_pct = 79;
        beats_sent     = 0;
        foreach (linked[i]) linked[i] = 1'b0;
        for (int n = 0; n < 16; n++)
        begin
            name_len[n]    = $urandom_range(1, 6);
            name_stored[n] = 1'b0;
            for (int i = 0; i < 6; i++) names[n][i] = 8'($urandom_range(1, 255));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every command, cache and chain corner cases.
        send(CMD_INSERT, 64'h0, 8'd0, 8'd0);
        send(CMD_INSERT, '1, 8'd255, 8'd255);
        send(CMD_FIND, '1, 8'd0, 8'd0);
        send(CMD_FIND, 64'h0, 8'd0, 8'd0);
        send(CMD_FIND, 64'h0, 8'd0, 8'd0);
        send(CMD_FIND, 64'h1234_0000_0000_00ff, 8'd0, 8'd0);
        send(CMD_NAME_BYTE, '0, '0, 8'd255);
        send(CMD_NAME_BYTE, '0, '0, 8'd0);
        send(CMD_NAME_BYTE, '0, '0, 8'd1);
        send(CMD_INS_NAME, '0, 8'd7, '0);
        send(CMD_NAME_BYTE, '0, '0, 8'd255);
        send(CMD_NAME_BYTE, '0, '0, 8'd1);
        send(CMD_FIND_NAME, '0, '0, '0);
        send(CMD_FIND_NAME, '0, '0, '0);
        send(CMD_RSVD6, '1, '1, '1);
        send(CMD_RSVD7, '1, '1, '1);
        // Relink slot 0 into its own bucket: the chain now loops on itself.
        send(CMD_INSERT, 64'h100, 8'd0, '0);
        send(CMD_FIND, 64'h100, '0, '0);
        send(CMD_FIND, 64'h0, '0, '0);
        send(CMD_FIND, 64'h200, '0, '0);
        send(CMD_CLEAR, '0, '0, '0);
        send(CMD_FIND, '1, '0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            send_gap_pct   = (phase == 0) ? 19 : (phase == 1) ? 79 : 0;
            recv_stall_pct = (phase == 0) ? 79 : (phase == 1) ? 19 : 0;
            while (beats_sent < 22 + 366 * (phase + 1))
                random_item();
        end

        drain();
        repeat (600) @(posedge clk);
        $display("Covered %0d command beats, %0d results checked, %0d finds hit.",
                 beats_sent, sb.checked, sb.hits);
        $display("Mix: clears, chained and relinked inserts, cached and walked finds, names.");
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/chl_pkg.sv
design/chl_ram.sv
design/chl_front.sv
design/chl_queue.sv
design/chl_back.sv
design/chained_hash_table_lookup.sv
test/tb_chained_hash_table_lookup.sv
